// ===== src/axis_calibrate_invert_deadzone_defines.svh =====
// Assertion macros for the axis calibration block.
`ifndef AXIS_CALIBRATE_INVERT_DEADZONE_DEFINES_SVH
`define AXIS_CALIBRATE_INVERT_DEADZONE_DEFINES_SVH
`ifndef SYNTHESIS
`define ACD_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("acd assertion failed");
`define ACD_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("acd assertion failed");
`else
`define ACD_ASSERT_IMPL(lbl, a, c)
`define ACD_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// ===== src/acd_pkg.sv =====
// Shared types and constants for the axis calibration block.
package acd_pkg;
  localparam logic [15:0] FULL     = 16'd32767;
  localparam logic [14:0] DZ_LIMIT = 15'd32734;
  localparam logic signed [16:0] SPAN_EPS = 17'sd3;

  localparam logic [2:0] REG_CAL_MIN = 3'd0;
  localparam logic [2:0] REG_CAL_CEN = 3'd1;
  localparam logic [2:0] REG_CAL_MAX = 3'd2;
  localparam logic [2:0] REG_INVERT  = 3'd3;
  localparam logic [2:0] REG_DZ      = 3'd4;

  typedef struct packed {
    logic        neg;
    logic        zero;
    logic        bypass;
    logic [15:0] val;
  } tag_t;

  typedef struct packed {
    logic        valid;
    logic        ovf;
    logic [15:0] rem;
    logic [15:0] lo;
    logic [15:0] q;
    logic [15:0] den;
    tag_t        tag;
  } div_t;
endpackage

// ===== src/acd_cell.sv =====
// One restoring-division cell: one quotient bit per cycle while en is high.
module acd_cell import acd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  div_t st_in,
  output div_t st_out
);
  div_t st_r, st_nxt;
  logic [16:0] r2;
  logic        ge;

  always_comb begin
    r2 = {st_in.rem, st_in.lo[15]};
    ge = (r2 >= {1'b0, st_in.den});
    st_nxt = st_in;
    st_nxt.rem = ge ? 16'(r2 - {1'b0, st_in.den}) : r2[15:0];
    st_nxt.lo  = {st_in.lo[14:0], 1'b0};
    st_nxt.q   = {st_in.q[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;
endmodule

// ===== src/acd_div.sv =====
// Pipelined saturating divider: overflow check then a chain of 16 cells.
module acd_div import acd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] dividend,
  input  logic [15:0] den,
  input  tag_t        tag_in,
  output logic        out_vld,
  output logic [14:0] q_sat,
  output tag_t        tag_out
);
  div_t chain [0:16];
  div_t front_r, front_nxt;

  always_comb begin
    front_nxt.valid = in_vld;
    front_nxt.ovf   = (dividend[31:16] >= den);
    front_nxt.rem   = dividend[31:16];
    front_nxt.lo    = dividend[15:0];
    front_nxt.q     = '0;
    front_nxt.den   = den;
    front_nxt.tag   = tag_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else if (en) begin
      front_r <= front_nxt;
    end
  end

  assign chain[0] = front_r;

  for (genvar i = 0; i < 16; i++) begin : g_cell
    acd_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .st_in  (chain[i]),
      .st_out (chain[i+1])
    );
  end

  assign out_vld = chain[16].valid;
  assign tag_out = chain[16].tag;
  assign q_sat   = (chain[16].ovf || chain[16].q[15]) ? FULL[14:0] : chain[16].q[14:0];
endmodule

// ===== src/axis_calibrate_invert_deadzone.sv =====
// Top level: axis calibration, inversion and deadzone pipeline.
//
//  channel | handshake        | payload
//  --------+------------------+-------------------------------------
//  in      | in_valid/stall   | in_axis_in (s16)
//  out     | out_valid/stall  | out_axis_out (s16), out_cal_bypassed
//  cfg     | cfg_we           | cfg_index, cfg_wdata
//
// One transaction per cycle while the output is not stalled; the stages in order
// are input stage, multiply, 17-stage divider, sign/invert stage, multiply, 17-stage divider, output.
// The two divider cell chains set the depth.
// Synchronous active-low reset clears all stage valid bits and resets config to its defaults.
// A stalled output holding a valid result freezes the whole pipeline; in_stall follows it.
`include "axis_calibrate_invert_deadzone_defines.svh"
module axis_calibrate_invert_deadzone import acd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_axis_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_axis_out,
  output logic               out_cal_bypassed,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  // config registers
  logic signed [15:0] cal_min_r, cal_cen_r, cal_max_r;
  logic               invert_r;
  logic [14:0]        dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_min_r <= -16'sd32767;
      cal_cen_r <= 16'sd0;
      cal_max_r <= 16'sd32767;
      invert_r  <= 1'b0;
      dz_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_MIN: cal_min_r <= cfg_wdata;
        REG_CAL_CEN: cal_cen_r <= cfg_wdata;
        REG_CAL_MAX: cal_max_r <= cfg_wdata;
        REG_INVERT:  invert_r  <= cfg_wdata[0];
        REG_DZ:      dz_r      <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves unless the output holds an untaken result
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage A: clamp, offset from center, pick side span
  logic signed [15:0] v_cl;
  logic signed [16:0] diff, span17, tot17;
  logic               cal_ok;
  logic               a_valid_r;
  logic [15:0]        a_mag_r, a_span_r;
  tag_t               a_tag_r, a_tag_nxt;

  always_comb begin
    v_cl   = (in_axis_in == -16'sd32768) ? -16'sd32767 : in_axis_in;
    diff   = 17'(v_cl) - 17'(cal_cen_r);
    tot17  = 17'(cal_max_r) - 17'(cal_min_r);
    cal_ok = (cal_min_r <= cal_cen_r) && (cal_cen_r <= cal_max_r) && (tot17 > SPAN_EPS);
    span17 = diff[16] ? (17'(cal_cen_r) - 17'(cal_min_r))
                      : (17'(cal_max_r) - 17'(cal_cen_r));
    a_tag_nxt.neg    = diff[16];
    a_tag_nxt.zero   = cal_ok && (span17 <= SPAN_EPS);
    a_tag_nxt.bypass = !cal_ok;
    a_tag_nxt.val    = v_cl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      a_mag_r   <= diff[16] ? 16'(-diff) : diff[15:0];
      a_span_r  <= span17[15:0];
      a_tag_r   <= a_tag_nxt;
    end
  end

  // stage B: magnitude times full scale
  logic        b_valid_r;
  logic [31:0] b_prod_r;
  logic [15:0] b_span_r;
  tag_t        b_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
      b_prod_r  <= 32'(a_mag_r) * 32'(FULL);
      b_span_r  <= a_span_r;
      b_tag_r   <= a_tag_r;
    end
  end

  logic        d1_valid;
  logic [14:0] d1_q;
  tag_t        d1_tag;

  acd_div u_div_cal (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (b_valid_r),
    .dividend (b_prod_r),
    .den      (b_span_r),
    .tag_in   (b_tag_r),
    .out_vld  (d1_valid),
    .q_sat    (d1_q),
    .tag_out  (d1_tag)
  );

  // stage C: sign, bypass, invert; split into magnitude and sign
  logic signed [15:0] v1, v2;
  logic               c_valid_r, c_neg_r, c_byp_r;
  logic [14:0]        c_mag_r;

  always_comb begin
    if (d1_tag.bypass)    v1 = d1_tag.val;
    else if (d1_tag.zero) v1 = '0;
    else if (d1_tag.neg)  v1 = -$signed({1'b0, d1_q});
    else                  v1 = $signed({1'b0, d1_q});
    v2 = invert_r ? -v1 : v1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= d1_valid;
      c_neg_r   <= v2[15];
      c_mag_r   <= v2[15] ? 15'(-v2) : v2[14:0];
      c_byp_r   <= d1_tag.bypass;
    end
  end

  // stage D: deadzone removal, scale numerator
  logic [14:0] dz;
  logic        in_dz;
  logic        d_valid_r;
  logic [31:0] d_prod_r;
  logic [15:0] d_den_r;
  tag_t        d_tag_r;

  always_comb begin
    dz    = (dz_r > DZ_LIMIT) ? DZ_LIMIT : dz_r;
    in_dz = (c_mag_r <= dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r      <= c_valid_r;
      d_prod_r       <= in_dz ? 32'd0 : 32'(c_mag_r - dz) * 32'(FULL);
      d_den_r        <= FULL - 16'(dz);
      d_tag_r.neg    <= c_neg_r;
      d_tag_r.zero   <= in_dz;
      d_tag_r.bypass <= c_byp_r;
      d_tag_r.val    <= '0;
    end
  end

  logic        d2_valid;
  logic [14:0] d2_q;
  tag_t        d2_tag;

  acd_div u_div_dz (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_valid_r),
    .dividend (d_prod_r),
    .den      (d_den_r),
    .tag_in   (d_tag_r),
    .out_vld  (d2_valid),
    .q_sat    (d2_q),
    .tag_out  (d2_tag)
  );

  // output register
  logic signed [15:0] out_axis_r, res;
  logic               out_byp_r;

  always_comb begin
    if (d2_tag.zero)     res = '0;
    else if (d2_tag.neg) res = -$signed({1'b0, d2_q});
    else                 res = $signed({1'b0, d2_q});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_valid;
      out_axis_r  <= res;
      out_byp_r   <= d2_tag.bypass;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_axis_out     = out_axis_r;
  assign out_cal_bypassed = out_byp_r;

  `ACD_ASSERT_IMPL(a_out_range, out_valid_r, out_axis_r != -16'sd32768)
  `ACD_ASSERT_NEXT(a_frozen, !en && !cfg_we, $stable(d_valid_r) && $stable(c_mag_r))
  `ACD_ASSERT_IMPL(a_dz_zero, d_valid_r && d_tag_r.zero, d_prod_r == 32'd0)
endmodule

// ===== sim/tb_axis_calibrate_invert_deadzone.sv =====
// Self-checking testbench for the axis calibration, inversion and deadzone pipeline.
module tb_axis_calibrate_invert_deadzone;
  import acd_pkg::*;

  localparam int FS = 32767;
  localparam int DZ_MAX = 32734;
  localparam int EPS = 3;
  localparam int PIPE_DEPTH = 39;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_axis_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_axis_out;
  logic               out_cal_bypassed;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_wdata;

  axis_calibrate_invert_deadzone dut (.*);

  typedef struct {
    logic signed [15:0] axis;
    logic               bypass;
  } axis_result_t;

  // Shadow copy of the configuration registers
  int cal_lo, cal_mid, cal_hi, dz_width;
  bit inv_en;

  axis_result_t pending_axis_q[$];
  int n_errors;
  bit rx_random;  // receiver stall pattern enabled

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Generous fixed bound on the run
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // sign(num) * min(|num| * FS / den, FS); truncates toward zero
  function automatic longint scale_full(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag * FS) / den;
    if (q > FS) q = FS;
    return (num < 0) ? -q : q;
  endfunction

  function automatic axis_result_t calc_axis(logic signed [15:0] raw);
    axis_result_t r;
    longint v, span, dz, mag, res;
    bit ok;
    v = raw;
    if (v < -FS) v = -FS;
    ok = (cal_lo <= cal_mid) && (cal_mid <= cal_hi) && ((cal_hi - cal_lo) > EPS);
    r.bypass = !ok;
    if (ok) begin
      span = (v >= cal_mid) ? (cal_hi - cal_mid) : (cal_mid - cal_lo);
      v = (span <= EPS) ? 0 : scale_full(v - cal_mid, span);
    end
    if (inv_en) v = -v;
    dz = (dz_width > DZ_MAX) ? DZ_MAX : dz_width;
    mag = (v < 0) ? -v : v;
    if (mag <= dz) res = 0;
    else begin
      res = scale_full(mag - dz, FS - dz);
      if (v < 0) res = -res;
    end
    r.axis = res[15:0];
    return r;
  endfunction

  // Register write; only called while the pipeline is drained.
  // The caller drops cfg_we after the last write.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      REG_CAL_MIN: cal_lo = $signed(val);
      REG_CAL_CEN: cal_mid = $signed(val);
      REG_CAL_MAX: cal_hi = $signed(val);
      REG_INVERT:  inv_en = val[0];
      REG_DZ:      dz_width = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_cal(int lo, int mid, int hi, bit inv, int dz);
    write_reg(REG_CAL_MIN, 16'(lo));
    write_reg(REG_CAL_CEN, 16'(mid));
    write_reg(REG_CAL_MAX, 16'(hi));
    write_reg(REG_INVERT, {15'd0, inv});
    write_reg(REG_DZ, 16'(dz));
    cfg_we <= 1'b0;
  endtask

  // Drive one transaction; returns at the falling edge after acceptance
  task automatic send_axis(logic signed [15:0] s);
    in_valid <= 1'b1;
    in_axis_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_axis_q.push_back(calc_axis(s));
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Wait until every expected transaction has returned, then let the pipe drain
  task automatic drain;
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_axis_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  // Receiver stall pattern: random bursts of stall, with quiet stretches
  initial begin
    int k;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      k = $urandom_range(0, 99);
      if (rx_random) out_stall <= (k < 30);
      else out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    axis_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_axis_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected transaction: axis_out=%0d", out_axis_out);
      end else begin
        e = pending_axis_q.pop_front();
        if (e.axis !== out_axis_out || e.bypass !== out_cal_bypassed) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp axis=%0d byp=%0b got axis=%0d byp=%0b",
                     e.axis, e.bypass, out_axis_out, out_cal_bypassed);
        end
      end
    end
  end

  task automatic test_directed_extremes;
    logic signed [15:0] pts[$];
    pts = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767, 16'sd16384};
    foreach (pts[i]) send_axis(pts[i]);
    drain();
    // invert plus max deadzone (clamped above the limit)
    set_cal(-32767, 0, 32767, 1'b1, 32767);
    foreach (pts[i]) send_axis(pts[i]);
    drain();
  endtask

  task automatic test_special_cal;
    // narrow upper side, valid overall
    set_cal(-20000, 1000, 1002, 1'b0, 100);
    send_axis(16'sd5000); send_axis(-16'sd5000); send_axis(16'sd1000);
    drain();
    // invalid: center outside range -> bypass
    set_cal(-100, 200, 100, 1'b0, 0);
    send_axis(16'sd300); send_axis(-16'sd32768);
    drain();
    // invalid: total span equals epsilon
    set_cal(10, 11, 13, 1'b1, 0);
    send_axis(16'sd12); send_axis(16'sd32767);
    drain();
    // register values of -32768 used as written
    set_cal(-32768, -32768, 32767, 1'b0, 32734);
    send_axis(-16'sd32768); send_axis(16'sd32767); send_axis(16'sd0);
    drain();
  endtask

  task automatic test_random_traffic;
    int phase, i, n, burst, k;
    logic signed [15:0] s;
    rx_random = 1'b1;
    for (phase = 0; phase < 8; phase++) begin
      k = $urandom_range(0, 3);
      if (k == 0)
        set_cal(-32767, 0, 32767, 1'($urandom_range(0, 1)), $urandom_range(0, 32767));
      else if (k == 1)
        set_cal($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
                1'($urandom_range(0, 1)), $urandom_range(0, 32767));
      else begin
        cal_lo = $urandom_range(0, 30000) - 32768;
        cal_hi = $urandom_range(0, 30000);
        set_cal(cal_lo, $urandom_range(0, 2000) - 1000, cal_hi,
                1'($urandom_range(0, 1)), $urandom_range(0, 4000));
      end
      i = 0;
      while (i < 200) begin
        burst = $urandom_range(1, 20);
        for (n = 0; n < burst; n++) begin
          s = 16'($urandom);
          send_axis(s);
          i++;
        end
        if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
      end
      // sender holds off until every transaction has returned
      drain();
    end
    rx_random = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_axis_in = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    n_errors = 0;
    rx_random = 1'b0;
    cal_lo = -32767; cal_mid = 0; cal_hi = 32767; inv_en = 1'b0; dz_width = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_extremes();
    test_special_cal();
    test_random_traffic();
    drain();
    if (n_errors == 0 && pending_axis_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/acd_pkg.sv
src/acd_cell.sv
src/acd_div.sv
src/axis_calibrate_invert_deadzone.sv
sim/tb_axis_calibrate_invert_deadzone.sv
